@@ design/crpf_pkg.sv @@
// crpf_pkg: shared constants for the circle pair repulsion force unit
// fixed point format, field widths, register indexes and pipeline latency
// no dependencies
package crpf_pkg;

    // fixed point format of positions, radii, range and stiffness
    localparam int FRAC_BITS  = 16;

    // field widths
    localparam int POS_W      = 32;
    localparam int RAD_W      = 31;
    localparam int STIFF_W    = 32;
    localparam int FORCE_W    = 48;

    // internal widths
    localparam int DIFF_W     = POS_W + 1;           // centre difference and magnitude
    localparam int REACH_W    = RAD_W + 2;           // sum of radii plus range
    localparam int SQ_W       = 2 * DIFF_W;          // squared distance
    localparam int ROOT_W     = SQ_W / 2;            // integer square root
    localparam int REM_W      = ROOT_W + 1;          // square root remainder
    localparam int M_W        = DIFF_W + STIFF_W;    // magnitude times stiffness
    localparam int PROD_W     = M_W + SQ_W;          // full force product
    localparam int MAG_W      = PROD_W - 3 * FRAC_BITS;

    // register indexes of the configuration port
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_RANGE = 1'b1;

    // register reset values
    localparam logic [STIFF_W-1:0] STIFF_RESET = STIFF_W'(64'd1 << FRAC_BITS);

    // start to done latency in cycles
    localparam int LATENCY    = 12 + ROOT_W;

endpackage

@@ design/circle_pair_repulsion_force_unit.sv @@
// circle_pair_repulsion_force_unit: short range repulsion between two circles
// fully pipelined, 33 stage digit-by-digit square root, split wide products
// depends on crpf_pkg
//
// result: done rises once the pair has passed the front, square root and back stages, one result word per pair
// throughput: one pair per cycle, set by the fully pipelined datapath; busy stays low
// the square root retires one root bit per stage, products are cut into 33x33 parts
// reset: rst_n asynchronous active low clears all valid bits and the two registers
// (stiffness 1.0, contact range 0); results cannot be held off by the receiver
module circle_pair_repulsion_force_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [crpf_pkg::POS_W-1:0] first_x,
    input  logic signed [crpf_pkg::POS_W-1:0] first_y,
    input  logic        [crpf_pkg::RAD_W-1:0] first_radius,
    input  logic signed [crpf_pkg::POS_W-1:0] second_x,
    input  logic signed [crpf_pkg::POS_W-1:0] second_y,
    input  logic        [crpf_pkg::RAD_W-1:0] second_radius,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crpf_pkg::STIFF_W-1:0]      cfg_data,
    output logic                              done,
    output logic signed [crpf_pkg::FORCE_W-1:0] force_x,
    output logic signed [crpf_pkg::FORCE_W-1:0] force_y,
    output logic                              in_contact,
    output logic                              saturated
);
    import crpf_pkg::*;

    localparam int SQ_STEPS = ROOT_W;

    // configuration registers
    logic [STIFF_W-1:0] stiffness_reg;
    logic [RAD_W-1:0]   contact_range_reg;

    // stage 1: differences and reach
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] d1_reg [2];
    logic [REACH_W-1:0]       s1_reg;

    // stage 2: magnitudes and signs
    logic                     v2_reg;
    logic [DIFF_W-1:0]        a2_reg [2];
    logic                     n2_reg [2];
    logic [REACH_W-1:0]       s2_reg;

    // stage 3: squares and stiffness products
    logic                     v3_reg;
    logic [SQ_W-1:0]          sq3_reg [2];
    logic [SQ_W-1:0]          ss3_reg;
    logic [M_W-1:0]           m3_reg [2];
    logic                     n3_reg [2];
    logic [REACH_W-1:0]       s3_reg;

    // stage 4: squared distance
    logic                     v4_reg;
    logic [SQ_W-1:0]          dist4_reg;
    logic [SQ_W-1:0]          ss4_reg;
    logic [M_W-1:0]           m4_reg [2];
    logic                     n4_reg [2];
    logic [REACH_W-1:0]       s4_reg;

    // square root pipeline, entry 0 is loaded with the contact test
    logic                     sq_v_reg    [SQ_STEPS+1];
    logic [SQ_W-1:0]          sq_rad_reg  [SQ_STEPS+1];
    logic [REM_W-1:0]         sq_rem_reg  [SQ_STEPS+1];
    logic [ROOT_W-1:0]        sq_root_reg [SQ_STEPS+1];
    logic                     sq_c_reg    [SQ_STEPS+1];
    logic [M_W-1:0]           sq_m_reg    [SQ_STEPS+1][2];
    logic                     sq_n_reg    [SQ_STEPS+1][2];
    logic [REACH_W-1:0]       sq_s_reg    [SQ_STEPS+1];

    // gap stage
    logic                     vg_reg;
    logic [REACH_W-1:0]       gap_reg;
    logic                     cg_reg;
    logic [M_W-1:0]           mg_reg [2];
    logic                     ng_reg [2];

    // squared gap stage
    logic                     vq_reg;
    logic [SQ_W-1:0]          g2_reg;
    logic                     cq_reg;
    logic [M_W-1:0]           mq_reg [2];
    logic                     nq_reg [2];

    // partial product stage
    logic                     vp_reg;
    logic                     cp_reg;
    logic                     np_reg [2];
    logic [SQ_W-1:0]          pp00_reg [2];
    logic [SQ_W-1:0]          pp01_reg [2];
    logic [SQ_W-1:0]          pp10_reg [2];
    logic [SQ_W-1:0]          pp11_reg [2];

    // middle sum stage
    logic                     vm_reg;
    logic                     cm_reg;
    logic                     nm_reg [2];
    logic [SQ_W-1:0]          pl_reg [2];
    logic [SQ_W:0]            mid_reg [2];
    logic [SQ_W-1:0]          ph_reg [2];

    // low sum stage
    logic                     vl_reg;
    logic                     cl_reg;
    logic                     nl_reg [2];
    logic [PROD_W-1:0]        low_reg [2];
    logic [SQ_W-1:0]          hi_reg [2];

    // full product stage
    logic                     vf_reg;
    logic                     cf_reg;
    logic                     nf_reg [2];
    logic [PROD_W-1:0]        prod_reg [2];

    // output word
    logic                     done_reg;
    logic [FORCE_W-1:0]       force_reg [2];
    logic                     contact_reg;
    logic                     sat_reg;

    // saturation of the final magnitudes
    logic [MAG_W-1:0]         mag_next   [2];
    logic [MAG_W-1:0]         limit_next [2];
    logic                     clip_next  [2];
    logic [FORCE_W-1:0]       clipped_next [2];
    logic [FORCE_W-1:0]       force_next [2];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg     <= STIFF_RESET;
            contact_range_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STIFFNESS:     stiffness_reg     <= cfg_data;
                REG_CONTACT_RANGE: contact_range_reg <= cfg_data[RAD_W-1:0];
                default:           ;
            endcase
        end
    end

    // valid bits of the fixed stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vg_reg   <= 1'b0;
            vq_reg   <= 1'b0;
            vp_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            vl_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            vg_reg   <= sq_v_reg[SQ_STEPS];
            vq_reg   <= vg_reg;
            vp_reg   <= vq_reg;
            vm_reg   <= vp_reg;
            vl_reg   <= vm_reg;
            vf_reg   <= vl_reg;
            done_reg <= vf_reg;
        end
    end

    // front stages: differences, magnitudes, squares, distance
    always_ff @(posedge clk)
    begin
        d1_reg[0] <= DIFF_W'(first_x) - DIFF_W'(second_x);
        d1_reg[1] <= DIFF_W'(first_y) - DIFF_W'(second_y);
        s1_reg    <= REACH_W'(first_radius) + REACH_W'(second_radius)
                   + REACH_W'(contact_range_reg);
        s2_reg    <= s1_reg;
        s3_reg    <= s2_reg;
        ss3_reg   <= SQ_W'(s2_reg) * SQ_W'(s2_reg);
        s4_reg    <= s3_reg;
        ss4_reg   <= ss3_reg;
        dist4_reg <= sq3_reg[0] + sq3_reg[1];
        for (int l = 0; l < 2; l++)
        begin
            n2_reg[l]  <= d1_reg[l][DIFF_W-1];
            a2_reg[l]  <= d1_reg[l][DIFF_W-1] ? DIFF_W'(-d1_reg[l]) : DIFF_W'(d1_reg[l]);
            n3_reg[l]  <= n2_reg[l];
            sq3_reg[l] <= SQ_W'(a2_reg[l]) * SQ_W'(a2_reg[l]);
            m3_reg[l]  <= M_W'(a2_reg[l]) * M_W'(stiffness_reg);
            n4_reg[l]  <= n3_reg[l];
            m4_reg[l]  <= m3_reg[l];
        end
    end

    // square root entry with the exact contact test
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else
            sq_v_reg[0] <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        sq_rad_reg[0]  <= dist4_reg;
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_c_reg[0]    <= dist4_reg <= ss4_reg;
        sq_s_reg[0]    <= s4_reg;
        for (int l = 0; l < 2; l++)
        begin
            sq_m_reg[0][l] <= m4_reg[l];
            sq_n_reg[0][l] <= n4_reg[l];
        end
    end

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [REM_W+1:0] shifted_next;
        logic [REM_W+1:0] trial_next;
        logic             fits_next;

        always_comb
        begin
            shifted_next = {sq_rem_reg[k], sq_rad_reg[k][SQ_W-1 -: 2]};
            trial_next   = (REM_W+2)'({sq_root_reg[k], 2'b01});
            fits_next    = shifted_next >= trial_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
            sq_rem_reg[k+1]  <= fits_next ? REM_W'(shifted_next - trial_next)
                                          : REM_W'(shifted_next);
            sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], fits_next};
            sq_c_reg[k+1]    <= sq_c_reg[k];
            sq_s_reg[k+1]    <= sq_s_reg[k];
            for (int l = 0; l < 2; l++)
            begin
                sq_m_reg[k+1][l] <= sq_m_reg[k][l];
                sq_n_reg[k+1][l] <= sq_n_reg[k][l];
            end
        end
    end

    // back stages: gap, squared gap, split product and its sums
    always_ff @(posedge clk)
    begin
        gap_reg <= sq_s_reg[SQ_STEPS] - REACH_W'(sq_root_reg[SQ_STEPS]);
        cg_reg  <= sq_c_reg[SQ_STEPS];
        g2_reg  <= SQ_W'(gap_reg) * SQ_W'(gap_reg);
        cq_reg  <= cg_reg;
        cp_reg  <= cq_reg;
        cm_reg  <= cp_reg;
        cl_reg  <= cm_reg;
        cf_reg  <= cl_reg;
        for (int l = 0; l < 2; l++)
        begin
            mg_reg[l]   <= sq_m_reg[SQ_STEPS][l];
            ng_reg[l]   <= sq_n_reg[SQ_STEPS][l];
            mq_reg[l]   <= mg_reg[l];
            nq_reg[l]   <= ng_reg[l];
            np_reg[l]   <= nq_reg[l];
            pp00_reg[l] <= SQ_W'(mq_reg[l][DIFF_W-1:0]) * SQ_W'(g2_reg[DIFF_W-1:0]);
            pp01_reg[l] <= SQ_W'(mq_reg[l][DIFF_W-1:0]) * SQ_W'(g2_reg[SQ_W-1:DIFF_W]);
            pp10_reg[l] <= SQ_W'(mq_reg[l][M_W-1:DIFF_W]) * SQ_W'(g2_reg[DIFF_W-1:0]);
            pp11_reg[l] <= SQ_W'(mq_reg[l][M_W-1:DIFF_W]) * SQ_W'(g2_reg[SQ_W-1:DIFF_W]);
            nm_reg[l]   <= np_reg[l];
            pl_reg[l]   <= pp00_reg[l];
            mid_reg[l]  <= (SQ_W+1)'(pp01_reg[l]) + (SQ_W+1)'(pp10_reg[l]);
            ph_reg[l]   <= pp11_reg[l];
            nl_reg[l]   <= nm_reg[l];
            low_reg[l]  <= PROD_W'(pl_reg[l]) + (PROD_W'(mid_reg[l]) << DIFF_W);
            hi_reg[l]   <= ph_reg[l];
            nf_reg[l]   <= nl_reg[l];
            prod_reg[l] <= low_reg[l] + (PROD_W'(hi_reg[l]) << (2 * DIFF_W));
        end
    end

    // shift out the fraction, clip and apply the sign
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag_next[l]     = prod_reg[l][PROD_W-1:3*FRAC_BITS];
            limit_next[l]   = nf_reg[l] ? (MAG_W'(1) << (FORCE_W-1))
                                        : ((MAG_W'(1) << (FORCE_W-1)) - MAG_W'(1));
            clip_next[l]    = mag_next[l] > limit_next[l];
            clipped_next[l] = clip_next[l] ? limit_next[l][FORCE_W-1:0]
                                           : mag_next[l][FORCE_W-1:0];
            force_next[l]   = !cf_reg ? '0
                            : (nf_reg[l] ? FORCE_W'(~clipped_next[l] + FORCE_W'(1))
                                         : clipped_next[l]);
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        force_reg[0] <= force_next[0];
        force_reg[1] <= force_next[1];
        contact_reg  <= cf_reg;
        sat_reg      <= cf_reg && (clip_next[0] || clip_next[1]);
    end

    assign done       = done_reg;
    assign force_x    = force_reg[0];
    assign force_y    = force_reg[1];
    assign in_contact = contact_reg;
    assign saturated  = sat_reg;

endmodule

@@ design/crpf_checker.sv @@
// crpf_checker: port level assertions for circle_pair_repulsion_force_unit
// attached to the top level by the bind statement at the end of this file
// depends on crpf_pkg
module crpf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              cfg_ready,
    input  logic                              done,
    input  logic signed [crpf_pkg::FORCE_W-1:0] force_x,
    input  logic signed [crpf_pkg::FORCE_W-1:0] force_y,
    input  logic                              in_contact,
    input  logic                              saturated
);
    import crpf_pkg::*;

    // every accepted pair yields its word after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result word missing after accepted pair");

    // a word out of contact carries no force
    a_no_contact: assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_contact |-> force_x == '0 && force_y == '0 && !saturated)
        else $error("force reported without contact");

    // a clipped force always has full magnitude
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> in_contact && (force_x[FORCE_W-2:0] == '1
            || force_x == {1'b1, {(FORCE_W-1){1'b0}}}
            || force_y[FORCE_W-2:0] == '1
            || force_y == {1'b1, {(FORCE_W-1){1'b0}}}))
        else $error("saturated word without a clipped component");

    // the pipeline never refuses a pair or a register write
    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("unit refused a word");

endmodule

bind circle_pair_repulsion_force_unit crpf_checker u_crpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cfg_ready  (cfg_ready),
    .done       (done),
    .force_x    (force_x),
    .force_y    (force_y),
    .in_contact (in_contact),
    .saturated  (saturated)
);

@@ tb/circle_pair_repulsion_force_unit_tb.sv @@
// circle_pair_repulsion_force_unit_tb: self-checking bench for the circle pair repulsion unit
// drives pairs and register writes, predicts each force word, checks every done strobe
// depends on crpf_pkg and circle_pair_repulsion_force_unit
`timescale 1ns / 100ps

module circle_pair_repulsion_force_unit_tb;

    import crpf_pkg::*;

    typedef struct packed {
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic                      in_contact;
        logic                      saturated;
    } force_word_t;

    // expected force words and a private copy of the two registers
    class force_scoreboard;
        force_word_t       pending_forces[$];
        logic [STIFF_W-1:0] stiffness;
        logic [RAD_W-1:0]   contact_range;
        int                 errors;
        int                 checked;
        int                 contacts;
        int                 clips;

        function new();
            stiffness     = STIFF_RESET;
            contact_range = '0;
            errors        = 0;
            checked       = 0;
            contacts      = 0;
            clips         = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [STIFF_W-1:0] data);
            if (idx == REG_STIFFNESS)
                stiffness = data;
            else if (idx == REG_CONTACT_RANGE)
                contact_range = data[RAD_W-1:0];
        endfunction

        // one force component: |diff| * stiffness * gap^2 >> 3F, clipped to 48 bits
        function logic [FORCE_W-1:0] scaled_component(logic signed [DIFF_W-1:0] diff,
                                                       logic [SQ_W-1:0] gap_sq,
                                                       inout bit clip);
            logic [DIFF_W-1:0]  mag;
            logic [139:0]       product;
            logic [139:0]       limit;
            logic [FORCE_W-1:0] result;
            mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            product = 140'(mag) * 140'(stiffness) * 140'(gap_sq);
            product = product >> (3 * FRAC_BITS);
            limit   = diff[DIFF_W-1] ? (140'(1) << 47) : ((140'(1) << 47) - 1);
            if (product > limit)
            begin
                clip    = 1'b1;
                product = limit;
            end
            result = product[FORCE_W-1:0];
            return diff[DIFF_W-1] ? -result : result;
        endfunction

        // work out the force word of one accepted pair
        function void note_pair(logic signed [POS_W-1:0] fx, logic signed [POS_W-1:0] fy,
                                logic [RAD_W-1:0] fr, logic signed [POS_W-1:0] sx,
                                logic signed [POS_W-1:0] sy, logic [RAD_W-1:0] sr);
            logic signed [DIFF_W-1:0] dx;
            logic signed [DIFF_W-1:0] dy;
            logic [DIFF_W-1:0]        adx;
            logic [DIFF_W-1:0]        ady;
            logic [REACH_W-1:0]       reach;
            logic [SQ_W-1:0]          dist_sq;
            logic [SQ_W-1:0]          reach_sq;
            logic [SQ_W-1:0]          trial_sq;
            logic [SQ_W-1:0]          gap_sq;
            logic [DIFF_W-1:0]        root;
            logic [DIFF_W-1:0]        trial;
            logic [REACH_W-1:0]       gap;
            force_word_t              word;
            bit                       clip;
            dx       = DIFF_W'(fx) - DIFF_W'(sx);
            dy       = DIFF_W'(fy) - DIFF_W'(sy);
            adx      = dx[DIFF_W-1] ? -dx : dx;
            ady      = dy[DIFF_W-1] ? -dy : dy;
            reach    = REACH_W'(fr) + REACH_W'(sr) + REACH_W'(contact_range);
            dist_sq  = SQ_W'(adx) * SQ_W'(adx) + SQ_W'(ady) * SQ_W'(ady);
            reach_sq = SQ_W'(reach) * SQ_W'(reach);
            word     = '0;
            clip     = 1'b0;
            if (dist_sq <= reach_sq)
            begin
                // floor square root, one bit at a time from the top
                root = '0;
                for (int i = DIFF_W - 1; i >= 0; i--)
                begin
                    trial    = root | (DIFF_W'(1) << i);
                    trial_sq = SQ_W'(trial) * SQ_W'(trial);
                    if (trial_sq <= dist_sq)
                        root = trial;
                end
                gap             = reach - REACH_W'(root);
                gap_sq          = SQ_W'(gap) * SQ_W'(gap);
                word.force_x    = scaled_component(dx, gap_sq, clip);
                word.force_y    = scaled_component(dy, gap_sq, clip);
                word.in_contact = 1'b1;
                word.saturated  = clip;
                contacts++;
                if (clip)
                    clips++;
            end
            pending_forces.push_back(word);
        endfunction

        // compare one done word with the oldest expectation
        function void check_force(force_word_t got);
            force_word_t want;
            if (pending_forces.size() == 0)
            begin
                $error("unexpected force word: force_x %0d force_y %0d", got.force_x,
                       got.force_y);
                errors++;
                return;
            end
            want = pending_forces.pop_front();
            checked++;
            if (got.force_x !== want.force_x)
            begin
                $error("force_x expected %0d actual %0d", want.force_x, got.force_x);
                errors++;
            end
            if (got.force_y !== want.force_y)
            begin
                $error("force_y expected %0d actual %0d", want.force_y, got.force_y);
                errors++;
            end
            if (got.in_contact !== want.in_contact)
            begin
                $error("in_contact expected %0b actual %0b", want.in_contact, got.in_contact);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $error("saturated expected %0b actual %0b", want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 115;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic signed [POS_W-1:0]    first_x;
    logic signed [POS_W-1:0]    first_y;
    logic        [RAD_W-1:0]    first_radius;
    logic signed [POS_W-1:0]    second_x;
    logic signed [POS_W-1:0]    second_y;
    logic        [RAD_W-1:0]    second_radius;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [STIFF_W-1:0]         cfg_data;
    logic                       done;
    logic signed [FORCE_W-1:0]  force_x;
    logic signed [FORCE_W-1:0]  force_y;
    logic                       in_contact;
    logic                       saturated;

    force_scoreboard            board;
    int                         quiet_cycles;
    int                         pairs_sent;
    bit                         allow_idle;

    circle_pair_repulsion_force_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_radius  (first_radius),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_radius (second_radius),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .force_x       (force_x),
        .force_y       (force_y),
        .in_contact    (in_contact),
        .saturated     (saturated)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_force('{force_x, force_y, in_contact, saturated});
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // random sender gap, usually none
    task automatic sender_gap();
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clk);
        end
    endtask

    // present one pair and hold it until the block takes the word
    task automatic send_pair(logic signed [POS_W-1:0] fx, logic signed [POS_W-1:0] fy,
                             logic [RAD_W-1:0] fr, logic signed [POS_W-1:0] sx,
                             logic signed [POS_W-1:0] sy, logic [RAD_W-1:0] sr);
        sender_gap();
        @(negedge clk);
        first_x       = fx;
        first_y       = fy;
        first_radius  = fr;
        second_x      = sx;
        second_y      = sy;
        second_radius = sr;
        start         = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_pair(fx, fy, fr, sx, sy, sr);
        pairs_sent++;
    endtask

    // wait until every expected word has come back
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (board.pending_forces.size() != 0)
            @(posedge clk);
    endtask

    // register write over the config channel, block idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [STIFF_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random pair: mostly close centres so contact is common, some fully random
    task automatic send_random_pair();
        logic signed [POS_W-1:0] fx;
        logic signed [POS_W-1:0] fy;
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic [RAD_W-1:0]        fr;
        logic [RAD_W-1:0]        sr;
        fx = $urandom;
        fy = $urandom;
        if ($urandom_range(0, 9) < 3)
        begin
            fr = RAD_W'($urandom);
            sr = RAD_W'($urandom);
            send_pair(fx, fy, fr, $urandom, $urandom, sr);
        end
        else
        begin
            ox = $signed($urandom) >>> $urandom_range(0, 31);
            oy = $signed($urandom) >>> $urandom_range(0, 31);
            fr = RAD_W'($urandom >> $urandom_range(1, 31));
            sr = RAD_W'($urandom >> $urandom_range(1, 31));
            send_pair(fx, fy, fr, fx + ox, fy + oy, sr);
        end
    endtask

    // directed corner pairs
    task automatic send_corner_pairs();
        logic signed [POS_W-1:0] pmax;
        logic signed [POS_W-1:0] pmin;
        logic [RAD_W-1:0]        rmax;
        pmax = {1'b0, {(POS_W-1){1'b1}}};
        pmin = {1'b1, {(POS_W-1){1'b0}}};
        rmax = '1;
        // coincident centres, zero and full radii
        send_pair(0, 0, '0, 0, 0, '0);
        send_pair(pmax, pmin, rmax, pmax, pmin, rmax);
        // widest separation, both signs
        send_pair(pmax, pmax, rmax, pmin, pmin, rmax);
        send_pair(pmin, pmin, rmax, pmax, pmax, rmax);
        send_pair(pmax, 0, '0, pmin, 0, '0);
        send_pair(0, pmin, rmax, 0, pmax, '0);
        // exactly touching, just beyond, just inside
        send_pair(32'sh0003_0000, 0, 31'h0001_0000, 0, 0, 31'h0002_0000);
        send_pair(32'sh0003_0001, 0, 31'h0001_0000, 0, 0, 31'h0002_0000);
        send_pair(0, -32'sh0002_ffff, 31'h0001_0000, 0, 0, 31'h0002_0000);
        send_pair(32'sh0003_0000, 32'sh0004_0000, 31'h0002_8000, 0, 0, 31'h0002_8000);
        // deep overlap, heavy force, both signs
        send_pair(32'sh0000_0001, -32'sh0000_0001, rmax, 0, 0, rmax);
        send_pair(-32'sh0100_0000, 32'sh0100_0000, rmax, 0, 0, rmax);
        send_pair(32'sh4000_0000, pmin, rmax, -32'sh4000_0000, pmin, rmax);
        // zero radii, apart
        send_pair(1, 1, '0, 0, 0, '0);
        send_pair(-5, 7, '0, 3, -2, '0);
    endtask

    initial
    begin
        logic [STIFF_W-1:0] phase_stiffness[5];
        logic [RAD_W-1:0]   phase_range[5];
        board         = new();
        quiet_cycles  = 0;
        pairs_sent    = 0;
        allow_idle    = 1'b1;
        rst_n         = 1'b0;
        start         = 1'b0;
        first_x       = '0;
        first_y       = '0;
        first_radius  = '0;
        second_x      = '0;
        second_y      = '0;
        second_radius = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_STIFFNESS;
        cfg_data      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // settings per phase: reset values first, then extremes, random values and a small fixed setting
        phase_stiffness = '{STIFF_RESET, '1, '0, $urandom, 32'h0000_0100};
        phase_range     = '{'0, '1, '0, RAD_W'($urandom >> $urandom_range(1, 31)),
                            31'h0000_8000};

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase != 0)
            begin
                write_register(REG_STIFFNESS, phase_stiffness[phase]);
                write_register(REG_CONTACT_RANGE, STIFF_W'(phase_range[phase]));
            end
            send_corner_pairs();
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // no idling in the final stretch
                if (phase == 4 && n >= RANDOM_PER_PHASE - 60)
                    allow_idle = 1'b0;
                send_random_pair();
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d pairs over 5 register settings, %0d words checked",
                 pairs_sent, board.checked);
        $display("%0d pairs in contact, %0d with a clipped force component",
                 board.contacts, board.clips);
        if (board.errors == 0 && board.pending_forces.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
design/crpf_pkg.sv
design/circle_pair_repulsion_force_unit.sv
design/crpf_checker.sv
tb/circle_pair_repulsion_force_unit_tb.sv
